/* design/gpns_pkg.sv */
package gpns_pkg;

	localparam int MaxColsDefault = 1024;
	localparam int MaxRowsDefault = 1024;

	localparam int AddrW = 5;
	localparam int DataW = 32;

	localparam logic [2:0] RegRowStart      = 3'd0;
	localparam logic [2:0] RegMinDisparity  = 3'd1;
	localparam logic [2:0] RegColCoef       = 3'd2;
	localparam logic [2:0] RegDispCoef      = 3'd3;
	localparam logic [2:0] RegRowOffset     = 3'd4;
	localparam logic [2:0] RegResiduumLimit = 3'd5;

	localparam logic [9:0]  RowStartReset      = 10'd240;
	localparam logic [11:0] MinDisparityReset  = 12'd0;
	localparam logic [31:0] CoefReset          = 32'd0;
	localparam logic [23:0] ResiduumLimitReset = 24'hFFFFFF;

	// band test runs in signed fixed point with 20 fraction bits
	localparam int DiffW = 48;

	localparam int AccColSqW   = 41;
	localparam int AccDispColW = 42;
	localparam int AccColW     = 30;
	localparam int AccDispSqW  = 44;
	localparam int AccDispW    = 32;
	localparam int AccColRowW  = 41;
	localparam int AccDispRowW = 42;
	localparam int AccRowW     = 30;
	localparam int AccCountW   = 21;

	typedef struct packed {
		logic [9:0]  pixel_row;
		logic [9:0]  pixel_col;
		logic [11:0] disparity;
		logic        frame_end;
	} pix_t;

	typedef struct packed {
		logic [39:0] sum_col_sq;
		logic [41:0] sum_disp_col;
		logic [29:0] sum_col;
		logic [43:0] sum_disp_sq;
		logic [31:0] sum_disp;
		logic [39:0] sum_col_row;
		logic [41:0] sum_disp_row;
		logic [29:0] sum_row;
		logic [20:0] inlier_count;
	} sums_t;

	typedef struct packed {
		logic [9:0]         row_start;
		logic [11:0]        min_disparity;
		logic signed [31:0] col_coef;
		logic signed [31:0] disp_coef;
		logic signed [31:0] row_offset;
		logic [23:0]        residuum_limit;
	} cfg_t;

	typedef struct packed {
		logic [19:0] col_sq;
		logic [21:0] disp_col;
		logic [9:0]  col;
		logic [23:0] disp_sq;
		logic [11:0] disp;
		logic [19:0] col_row;
		logic [21:0] disp_row;
		logic [9:0]  row;
	} terms_t;

	typedef struct packed {
		logic valid;
		logic inlier;
		logic last;
	} ctl_t;

endpackage

/* design/gated_plane_normal_sums.sv */
// Plane-fit sum accumulator. Takes one disparity pixel per clock (row, column,
// Q8.4 disparity, frame_end) and keeps nine sums over the inlier pixels: those
// inside the image, at or below row_start, with disparity above min_disparity
// and whose row lies strictly within residuum_limit of
// col_coef*col + disp_coef*disp + row_offset. On the frame_end pixel the sums,
// that pixel included, go out as one word and restart from zero. The datapath
// is a four-register pipeline (input, coefficient products, band distance,
// inlier flag with terms) feeding the accumulators and the output register, so
// a pixel enters every cycle the pipe advances; its sums word is registered
// as the frame_end pixel leaves the last stage. Input stalls only while a
// finished sums word is held by sums_stall and the next frame_end pixel has
// reached the accumulators. APB writes the registers at byte address 4*i.
module gated_plane_normal_sums #(
	parameter int MAX_COLS = gpns_pkg::MaxColsDefault,
	parameter int MAX_ROWS = gpns_pkg::MaxRowsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpns_pkg::AddrW-1:0]  paddr,
	input  logic [gpns_pkg::DataW-1:0]  pwdata,
	output logic [gpns_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  gpns_pkg::pix_t              pix,
	output logic                        sums_valid,
	input  logic                        sums_stall,
	output gpns_pkg::sums_t             sums
);

	gpns_pkg::cfg_t   cfg;
	gpns_pkg::ctl_t   ctl;
	gpns_pkg::terms_t terms;
	logic             adv;

	// the whole pipe holds only when a frame_end word cannot be handed over
	assign adv       = !(sums_valid && sums_stall) || !(ctl.valid && ctl.last);
	assign pix_stall = !adv;

	gpns_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpns_gate #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_gate (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pix_valid (pix_valid),
		.pix       (pix),
		.cfg       (cfg),
		.ctl       (ctl),
		.terms     (terms)
	);

	gpns_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl        (ctl),
		.terms      (terms),
		.sums_stall (sums_stall),
		.sums_valid (sums_valid),
		.sums       (sums)
	);

endmodule

/* design/gpns_regs.sv */
module gpns_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpns_pkg::AddrW-1:0]  paddr,
	input  logic [gpns_pkg::DataW-1:0]  pwdata,
	output logic [gpns_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output gpns_pkg::cfg_t              cfg
);

	gpns_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr;

	assign idx    = paddr[gpns_pkg::AddrW-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_start      <= gpns_pkg::RowStartReset;
			cfg_q.min_disparity  <= gpns_pkg::MinDisparityReset;
			cfg_q.col_coef       <= gpns_pkg::CoefReset;
			cfg_q.disp_coef      <= gpns_pkg::CoefReset;
			cfg_q.row_offset     <= gpns_pkg::CoefReset;
			cfg_q.residuum_limit <= gpns_pkg::ResiduumLimitReset;
		end else if (wr) begin
			case (idx)
				gpns_pkg::RegRowStart:      cfg_q.row_start      <= pwdata[9:0];
				gpns_pkg::RegMinDisparity:  cfg_q.min_disparity  <= pwdata[11:0];
				gpns_pkg::RegColCoef:       cfg_q.col_coef       <= pwdata;
				gpns_pkg::RegDispCoef:      cfg_q.disp_coef      <= pwdata;
				gpns_pkg::RegRowOffset:     cfg_q.row_offset     <= pwdata;
				gpns_pkg::RegResiduumLimit: cfg_q.residuum_limit <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gpns_pkg::RegRowStart:      prdata = 32'(cfg_q.row_start);
			gpns_pkg::RegMinDisparity:  prdata = 32'(cfg_q.min_disparity);
			gpns_pkg::RegColCoef:       prdata = cfg_q.col_coef;
			gpns_pkg::RegDispCoef:      prdata = cfg_q.disp_coef;
			gpns_pkg::RegRowOffset:     prdata = cfg_q.row_offset;
			gpns_pkg::RegResiduumLimit: prdata = 32'(cfg_q.residuum_limit);
			default:                    prdata = '0;
		endcase
	end

endmodule

/* design/gpns_gate.sv */
module gpns_gate #(
	parameter int MAX_COLS = gpns_pkg::MaxColsDefault,
	parameter int MAX_ROWS = gpns_pkg::MaxRowsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              pix_valid,
	input  gpns_pkg::pix_t    pix,
	input  gpns_pkg::cfg_t    cfg,
	output gpns_pkg::ctl_t    ctl,
	output gpns_pkg::terms_t  terms
);

	localparam int DW = gpns_pkg::DiffW;

	// s1: input word
	logic                  v_s1;
	gpns_pkg::pix_t        pix_s1;

	// s2: coefficient products and plain gates
	logic                  v_s2;
	gpns_pkg::pix_t        pix_s2;
	logic                  gate_s2;
	logic signed [42:0]    pc_s2;
	logic signed [44:0]    pd_s2;

	// s3: signed distance from predicted row
	logic                  v_s3;
	gpns_pkg::pix_t        pix_s3;
	logic                  gate_s3;
	logic signed [DW-1:0]  diff_s3;

	// s4: inlier flag and sum terms
	logic                  v_s4;
	logic                  last_s4;
	logic                  inlier_s4;
	gpns_pkg::terms_t      terms_s4;

	logic                  range_ok;
	logic                  gate_c;
	logic signed [DW-1:0]  diff_c;
	logic [DW-1:0]         mag_c;
	logic [DW-1:0]         lim_c;
	gpns_pkg::terms_t      terms_c;

	assign range_ok = (int'(pix_s1.pixel_col) < MAX_COLS) && (int'(pix_s1.pixel_row) < MAX_ROWS);
	assign gate_c   = range_ok && (pix_s1.pixel_row >= cfg.row_start)
	                  && (pix_s1.disparity > cfg.min_disparity);

	assign diff_c = (DW'(pc_s2) <<< 4) + DW'(pd_s2) + (DW'(cfg.row_offset) <<< 4)
	                - $signed({18'd0, pix_s2.pixel_row, 20'd0});

	assign mag_c = diff_s3[DW-1] ? DW'(-diff_s3) : DW'(diff_s3);
	assign lim_c = DW'({cfg.residuum_limit, 12'd0});

	always_comb begin
		terms_c.col_sq   = 20'(pix_s3.pixel_col) * 20'(pix_s3.pixel_col);
		terms_c.disp_col = 22'(pix_s3.disparity) * 22'(pix_s3.pixel_col);
		terms_c.col      = pix_s3.pixel_col;
		terms_c.disp_sq  = 24'(pix_s3.disparity) * 24'(pix_s3.disparity);
		terms_c.disp     = pix_s3.disparity;
		terms_c.col_row  = 20'(pix_s3.pixel_col) * 20'(pix_s3.pixel_row);
		terms_c.disp_row = 22'(pix_s3.disparity) * 22'(pix_s3.pixel_row);
		terms_c.row      = pix_s3.pixel_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= pix;
			pix_s2    <= pix_s1;
			gate_s2   <= gate_c;
			pc_s2     <= cfg.col_coef * $signed({1'b0, pix_s1.pixel_col});
			pd_s2     <= cfg.disp_coef * $signed({1'b0, pix_s1.disparity});
			pix_s3    <= pix_s2;
			gate_s3   <= gate_s2;
			diff_s3   <= diff_c;
			last_s4   <= pix_s3.frame_end;
			inlier_s4 <= gate_s3 && (mag_c < lim_c);
			terms_s4  <= terms_c;
		end
	end

	assign ctl.valid  = v_s4;
	assign ctl.inlier = inlier_s4;
	assign ctl.last   = last_s4;
	assign terms      = terms_s4;

endmodule

/* design/gpns_accum.sv */
module gpns_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  gpns_pkg::ctl_t    ctl,
	input  gpns_pkg::terms_t  terms,
	input  logic              sums_stall,
	output logic              sums_valid,
	output gpns_pkg::sums_t   sums
);

	logic [gpns_pkg::AccColSqW-1:0]   col_sq_q,   col_sq_n;
	logic [gpns_pkg::AccDispColW-1:0] disp_col_q, disp_col_n;
	logic [gpns_pkg::AccColW-1:0]     col_q,      col_n;
	logic [gpns_pkg::AccDispSqW-1:0]  disp_sq_q,  disp_sq_n;
	logic [gpns_pkg::AccDispW-1:0]    disp_q,     disp_n;
	logic [gpns_pkg::AccColRowW-1:0]  col_row_q,  col_row_n;
	logic [gpns_pkg::AccDispRowW-1:0] disp_row_q, disp_row_n;
	logic [gpns_pkg::AccRowW-1:0]     row_q,      row_n;
	logic [gpns_pkg::AccCountW-1:0]   count_q,    count_n;

	logic            step;
	logic            valid_q;
	gpns_pkg::sums_t sums_q;

	assign step = adv && ctl.valid;

	always_comb begin
		col_sq_n   = col_sq_q;
		disp_col_n = disp_col_q;
		col_n      = col_q;
		disp_sq_n  = disp_sq_q;
		disp_n     = disp_q;
		col_row_n  = col_row_q;
		disp_row_n = disp_row_q;
		row_n      = row_q;
		count_n    = count_q;
		if (ctl.inlier) begin
			col_sq_n   = col_sq_q   + gpns_pkg::AccColSqW'(terms.col_sq);
			disp_col_n = disp_col_q + gpns_pkg::AccDispColW'(terms.disp_col);
			col_n      = col_q      + gpns_pkg::AccColW'(terms.col);
			disp_sq_n  = disp_sq_q  + gpns_pkg::AccDispSqW'(terms.disp_sq);
			disp_n     = disp_q     + gpns_pkg::AccDispW'(terms.disp);
			col_row_n  = col_row_q  + gpns_pkg::AccColRowW'(terms.col_row);
			disp_row_n = disp_row_q + gpns_pkg::AccDispRowW'(terms.disp_row);
			row_n      = row_q      + gpns_pkg::AccRowW'(terms.row);
			count_n    = count_q    + gpns_pkg::AccCountW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sq_q   <= '0;
			disp_col_q <= '0;
			col_q      <= '0;
			disp_sq_q  <= '0;
			disp_q     <= '0;
			col_row_q  <= '0;
			disp_row_q <= '0;
			row_q      <= '0;
			count_q    <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (step) begin
				if (ctl.last) begin
					col_sq_q   <= '0;
					disp_col_q <= '0;
					col_q      <= '0;
					disp_sq_q  <= '0;
					disp_q     <= '0;
					col_row_q  <= '0;
					disp_row_q <= '0;
					row_q      <= '0;
					count_q    <= '0;
				end else begin
					col_sq_q   <= col_sq_n;
					disp_col_q <= disp_col_n;
					col_q      <= col_n;
					disp_sq_q  <= disp_sq_n;
					disp_q     <= disp_n;
					col_row_q  <= col_row_n;
					disp_row_q <= disp_row_n;
					row_q      <= row_n;
					count_q    <= count_n;
				end
			end
			if (step && ctl.last) begin
				valid_q <= 1'b1;
			end else if (!sums_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && ctl.last) begin
			sums_q.sum_col_sq   <= col_sq_n[39:0];
			sums_q.sum_disp_col <= disp_col_n;
			sums_q.sum_col      <= col_n;
			sums_q.sum_disp_sq  <= disp_sq_n;
			sums_q.sum_disp     <= disp_n;
			sums_q.sum_col_row  <= col_row_n[39:0];
			sums_q.sum_disp_row <= disp_row_n;
			sums_q.sum_row      <= row_n;
			sums_q.inlier_count <= count_n;
		end
	end

	assign sums_valid = valid_q;
	assign sums       = sums_q;

endmodule

/* test/gated_plane_normal_sums_tb.sv */
module gated_plane_normal_sums_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpns_pkg::*;

	localparam int DrainCycles = 12;
	localparam logic [2:0] RegUnused = 3'd6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic sums_valid;
	logic sums_stall = 1'b0;
	sums_t sums;

	// predictor state
	cfg_t plane_cfg;
	logic [AccColSqW-1:0] acc_col_sq = '0;
	logic [AccDispColW-1:0] acc_disp_col = '0;
	logic [AccColW-1:0] acc_col = '0;
	logic [AccDispSqW-1:0] acc_disp_sq = '0;
	logic [AccDispW-1:0] acc_disp = '0;
	logic [AccColRowW-1:0] acc_col_row = '0;
	logic [AccDispRowW-1:0] acc_disp_row = '0;
	logic [AccRowW-1:0] acc_row = '0;
	logic [AccCountW-1:0] acc_count = '0;
	sums_t pending_sums[$];

	int send_idle_pct = 37;
	int recv_idle_pct = 62;
	int mismatch_count = 0;

	gated_plane_normal_sums dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t %s: got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic pix_t make_pixel(int row, int col, int disp, bit last);
		pix_t p;
		p.pixel_row = 10'(row);
		p.pixel_col = 10'(col);
		p.disparity = 12'(disp);
		p.frame_end = last;
		return p;
	endfunction

	// predicted row, signed, 20 fraction bits
	function automatic longint predicted_row_q20(logic [9:0] col, logic [11:0] disp);
		return longint'($signed(plane_cfg.col_coef)) * longint'(col) * 16
			+ longint'($signed(plane_cfg.disp_coef)) * longint'(disp)
			+ longint'($signed(plane_cfg.row_offset)) * 16;
	endfunction

	function automatic bit is_inlier(pix_t p);
		longint diff;
		if (p.pixel_col >= MaxColsDefault || p.pixel_row >= MaxRowsDefault) return 1'b0;
		if (p.pixel_row < plane_cfg.row_start || p.disparity <= plane_cfg.min_disparity)
			return 1'b0;
		diff = predicted_row_q20(p.pixel_col, p.disparity) - longint'(p.pixel_row) * 1048576;
		if (diff < 0) diff = -diff;
		return diff < (longint'(plane_cfg.residuum_limit) << 12);
	endfunction

	task automatic tally_pixel(input pix_t p);
		sums_t s;
		if (is_inlier(p)) begin
			acc_col_sq += p.pixel_col * p.pixel_col;
			acc_disp_col += p.disparity * p.pixel_col;
			acc_col += p.pixel_col;
			acc_disp_sq += p.disparity * p.disparity;
			acc_disp += p.disparity;
			acc_col_row += p.pixel_col * p.pixel_row;
			acc_disp_row += p.disparity * p.pixel_row;
			acc_row += p.pixel_row;
			acc_count += 1'b1;
		end
		if (p.frame_end) begin
			s.sum_col_sq = acc_col_sq[39:0];
			s.sum_disp_col = acc_disp_col;
			s.sum_col = acc_col;
			s.sum_disp_sq = acc_disp_sq;
			s.sum_disp = acc_disp;
			s.sum_col_row = acc_col_row[39:0];
			s.sum_disp_row = acc_disp_row;
			s.sum_row = acc_row;
			s.inlier_count = acc_count;
			pending_sums.push_back(s);
			acc_col_sq = '0;
			acc_disp_col = '0;
			acc_col = '0;
			acc_disp_sq = '0;
			acc_disp = '0;
			acc_col_row = '0;
			acc_disp_row = '0;
			acc_row = '0;
			acc_count = '0;
		end
	endtask

	task automatic compare_sums(input sums_t got, input sums_t want);
		if (got.sum_col_sq !== want.sum_col_sq)
			report_mismatch("sum_col_sq", got.sum_col_sq, want.sum_col_sq);
		if (got.sum_disp_col !== want.sum_disp_col)
			report_mismatch("sum_disp_col", got.sum_disp_col, want.sum_disp_col);
		if (got.sum_col !== want.sum_col)
			report_mismatch("sum_col", got.sum_col, want.sum_col);
		if (got.sum_disp_sq !== want.sum_disp_sq)
			report_mismatch("sum_disp_sq", got.sum_disp_sq, want.sum_disp_sq);
		if (got.sum_disp !== want.sum_disp)
			report_mismatch("sum_disp", got.sum_disp, want.sum_disp);
		if (got.sum_col_row !== want.sum_col_row)
			report_mismatch("sum_col_row", got.sum_col_row, want.sum_col_row);
		if (got.sum_disp_row !== want.sum_disp_row)
			report_mismatch("sum_disp_row", got.sum_disp_row, want.sum_disp_row);
		if (got.sum_row !== want.sum_row)
			report_mismatch("sum_row", got.sum_row, want.sum_row);
		if (got.inlier_count !== want.inlier_count)
			report_mismatch("inlier_count", got.inlier_count, want.inlier_count);
	endtask

	always @(posedge clk) begin
		if (arst_n && sums_valid && !sums_stall) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("sums word with none pending", 64'd0, 64'd0);
			end else begin
				compare_sums(sums, pending_sums.pop_front());
			end
		end
		sums_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic apb_access(input logic [2:0] idx, input bit write,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] unused_rd;
		apb_access(idx, 1'b1, value, unused_rd);
		case (idx)
			RegRowStart: plane_cfg.row_start = value[9:0];
			RegMinDisparity: plane_cfg.min_disparity = value[11:0];
			RegColCoef: plane_cfg.col_coef = value;
			RegDispCoef: plane_cfg.disp_coef = value;
			RegRowOffset: plane_cfg.row_offset = value;
			RegResiduumLimit: plane_cfg.residuum_limit = value[23:0];
			default: ;
		endcase
	endtask

	task automatic readback_config();
		logic [31:0] v;
		apb_access(RegRowStart, 1'b0, '0, v);
		if (v[9:0] !== plane_cfg.row_start)
			report_mismatch("row_start readback", v, plane_cfg.row_start);
		apb_access(RegMinDisparity, 1'b0, '0, v);
		if (v[11:0] !== plane_cfg.min_disparity)
			report_mismatch("min_disparity readback", v, plane_cfg.min_disparity);
		apb_access(RegColCoef, 1'b0, '0, v);
		if (v !== plane_cfg.col_coef)
			report_mismatch("col_coef readback", v, plane_cfg.col_coef);
		apb_access(RegDispCoef, 1'b0, '0, v);
		if (v !== plane_cfg.disp_coef)
			report_mismatch("disp_coef readback", v, plane_cfg.disp_coef);
		apb_access(RegRowOffset, 1'b0, '0, v);
		if (v !== plane_cfg.row_offset)
			report_mismatch("row_offset readback", v, plane_cfg.row_offset);
		apb_access(RegResiduumLimit, 1'b0, '0, v);
		if (v[23:0] !== plane_cfg.residuum_limit)
			report_mismatch("residuum_limit readback", v, plane_cfg.residuum_limit);
	endtask

	task automatic send_pixel(input pix_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		tally_pixel(p);
	endtask

	// wait out pending words and pixels still in the pipeline
	task automatic drain_pipeline();
		pix_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] rs, input logic [31:0] md,
			input logic [31:0] cc, input logic [31:0] dc, input logic [31:0] ro,
			input logic [31:0] rl);
		drain_pipeline();
		write_register(RegRowStart, rs);
		write_register(RegMinDisparity, md);
		write_register(RegColCoef, cc);
		write_register(RegDispCoef, dc);
		write_register(RegRowOffset, ro);
		write_register(RegResiduumLimit, rl);
		readback_config();
	endtask

	task automatic test_reset_values();
		readback_config();
	endtask

	// reset config: zero plane, widest band, so only row and disparity gate
	task automatic test_gating_edges();
		send_pixel(make_pixel(239, 5, 16, 0));
		send_pixel(make_pixel(240, 5, 16, 0));
		send_pixel(make_pixel(240, 7, 0, 0));
		send_pixel(make_pixel(241, 6, 1, 0));
		send_pixel(make_pixel(1023, 1023, 4095, 0));
		send_pixel(make_pixel(0, 0, 0, 0));
		send_pixel(make_pixel(1023, 0, 4095, 1));
		send_pixel(make_pixel(0, 0, 0, 1));
		send_pixel(make_pixel(1023, 1023, 4095, 1));
	endtask

	task automatic test_band_edges();
		// flat plane at row 500, band of 2 rows, edges excluded
		set_config(0, 100, 0, 0, 32'd500 << 16, 32'd2 << 8);
		send_pixel(make_pixel(498, 10, 200, 0));
		send_pixel(make_pixel(499, 20, 200, 0));
		send_pixel(make_pixel(501, 30, 200, 0));
		send_pixel(make_pixel(502, 40, 200, 0));
		send_pixel(make_pixel(500, 50, 100, 0));
		send_pixel(make_pixel(500, 60, 101, 1));
		// falling plane: row = 1023 - col + disp/256, band of 1 row
		set_config(0, 0, 32'hFFFF_0000, 32'd1 << 12, 32'd1023 << 16, 32'd1 << 8);
		send_pixel(make_pixel(924, 100, 256, 0));
		send_pixel(make_pixel(923, 100, 256, 0));
		send_pixel(make_pixel(0, 1023, 1, 1));
	endtask

	task automatic test_coef_extremes();
		set_config(1023, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
		send_pixel(make_pixel(1023, 1023, 4095, 1));
		set_config(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_pixel(make_pixel(512, 512, 2048, 1));
		set_config(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF);
		send_pixel(make_pixel(1023, 0, 1, 1));
	endtask

	task automatic test_unused_register();
		drain_pipeline();
		write_register(RegUnused, 32'hFFFF_FFFF);
		readback_config();
		send_pixel(make_pixel(300, 300, 300, 1));
	endtask

	// frames of random length; most rows are placed around the plane
	task automatic test_random_frames(input int send_pct, input int recv_pct);
		pix_t p;
		int left;
		int band;
		int row;
		drain_pipeline();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		left = 0;
		for (int ph = 0; ph < 4; ph++) begin
			if ($urandom_range(3) == 0) begin
				set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				set_config($urandom_range(0, 400), $urandom_range(0, 300),
					$urandom_range(0, 131072) - 65536, $urandom_range(0, 16384) - 8192,
					$urandom_range(0, 1000 << 16), $urandom_range(0, 40 << 8));
			end
			band = (plane_cfg.residuum_limit >> 8) + 2;
			if (band > 64) band = 64;
			for (int i = 0; i < 70; i++) begin
				if (left == 0) left = $urandom_range(1, 24);
				left--;
				p.pixel_col = 10'($urandom);
				p.disparity = 12'($urandom);
				p.frame_end = (left == 0);
				if ($urandom_range(3) == 0) begin
					p.pixel_row = 10'($urandom);
				end else begin
					row = int'(predicted_row_q20(p.pixel_col, p.disparity) >>> 20)
						+ int'($urandom_range(0, 2 * band)) - band;
					if (row < 0) row = 0;
					else if (row > 1023) row = 1023;
					p.pixel_row = 10'(row);
				end
				send_pixel(p);
			end
		end
	endtask

	initial begin
		plane_cfg.row_start = RowStartReset;
		plane_cfg.min_disparity = MinDisparityReset;
		plane_cfg.col_coef = CoefReset;
		plane_cfg.disp_coef = CoefReset;
		plane_cfg.row_offset = CoefReset;
		plane_cfg.residuum_limit = ResiduumLimitReset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_gating_edges();
		test_band_edges();
		test_coef_extremes();
		test_unused_register();
		test_random_frames(37, 62);
		test_random_frames(62, 37);
		test_random_frames(0, 0);
		drain_pipeline();
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
design/gpns_pkg.sv
design/gpns_regs.sv
design/gpns_gate.sv
design/gpns_accum.sv
design/gated_plane_normal_sums.sv
test/gated_plane_normal_sums_tb.sv
